### rtl/vector_autocorrelation_lags_defines.svh
// assertion helpers for the top-level rtl file
`ifndef VECTOR_AUTOCORRELATION_LAGS_DEFINES_SVH
`define VECTOR_AUTOCORRELATION_LAGS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define VAL_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define VAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/vacl_pkg.sv
// ----------------------------------------------------------------------------
// vacl_pkg
// Shared constants, lane control types and helpers for the lag correlator.
// ----------------------------------------------------------------------------
package vacl_pkg;

  localparam int LAGS        = 64;
  localparam int NUM_LANES   = 4;
  localparam int LANE_DEPTH  = LAGS / NUM_LANES;
  localparam int LANE_AW     = $clog2(LANE_DEPTH);
  localparam int LANE_IDX_W  = $clog2(NUM_LANES);
  localparam int STEP_W      = $clog2(NUM_LANES + 1);
  localparam int LAG_W       = $clog2(LAGS);
  localparam int LAGC_W      = LAG_W + 1;
  localparam int COMP_W      = 16;
  localparam int HIST_W      = 3 * COMP_W;
  localparam int SPACING_W   = 16;
  localparam int MAXLAG_W    = 7;
  localparam int SUM_W       = 64;
  localparam int CNT_W       = 32;
  localparam int TIME_W      = 32;
  localparam int DIVIDEND_W  = 64;
  localparam int DIVISOR_W   = 34;

  localparam logic [31:0] MEAN_LIMIT = 32'h4000_0000;

  localparam logic REG_MAX_LAG        = 1'b0;
  localparam logic REG_ORIGIN_SPACING = 1'b1;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_READOUT = 1'b1;

  typedef struct packed {
    logic                  rd_en;
    logic                  acc_en;
    logic [LANE_AW-1:0]    bank_addr;
    logic [LAG_W-1:0]      hist_raddr;
    logic                  hist_we;
    logic [LAG_W-1:0]      hist_waddr;
    logic [HIST_W-1:0]     hist_wdata;
    logic [COMP_W-1:0]     cur_x;
    logic [COMP_W-1:0]     cur_y;
    logic [COMP_W-1:0]     cur_z;
  } lane_ctl_t;

  typedef struct packed {
    logic [LANE_DEPTH-1:0] vld_map;
    logic [SUM_W-1:0]      sum;
    logic [CNT_W-1:0]      cnt;
  } lane_resp_t;

  // (r - d) mod sp for r < sp, d <= NUM_LANES, sp >= 1
  function automatic logic [SPACING_W-1:0] mod_sub(input logic [SPACING_W-1:0] r,
                                                   input logic [STEP_W-1:0] d,
                                                   input logic [SPACING_W-1:0] sp);
    logic signed [SPACING_W+1:0] v;
    v = $signed({2'b00, r}) - $signed({{(SPACING_W+2-STEP_W){1'b0}}, d});
    for (int i = 0; i < NUM_LANES; i++) begin
      if (v < 0) v = v + $signed({2'b00, sp});
    end
    return v[SPACING_W-1:0];
  endfunction

endpackage

### rtl/vacl_if.sv
// ----------------------------------------------------------------------------
// vacl_in_if / vacl_out_if
// Valid/ready channels for sample and readout beats and for lag results.
// ----------------------------------------------------------------------------
interface vacl_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] sample_time;
  logic [15:0] comp_x;
  logic [15:0] comp_y;
  logic [15:0] comp_z;
  modport source (output valid, cmd, sample_time, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, cmd, sample_time, comp_x, comp_y, comp_z, output ready);
endinterface

interface vacl_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  lag;
  logic [31:0] elapsed_time;
  logic [31:0] mean_correlation;
  logic [31:0] pair_count;
  logic        last;
  modport source (output valid, lag, elapsed_time, mean_correlation, pair_count, last,
                  input ready);
  modport sink   (input valid, lag, elapsed_time, mean_correlation, pair_count, last,
                  output ready);
endinterface

### rtl/vacl_lane.sv
// ----------------------------------------------------------------------------
// vacl_lane
// One correlation lane: history copy, lag accumulator bank, 3-stage MAC.
// ----------------------------------------------------------------------------
module vacl_lane import vacl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctl_t  ctl,
  output lane_resp_t resp
);

  logic [HIST_W-1:0] hist_mem [LAGS];
  logic [SUM_W-1:0]  sum_mem  [LANE_DEPTH];
  logic [CNT_W-1:0]  cnt_mem  [LANE_DEPTH];
  logic [LANE_DEPTH-1:0] vld_r;

  logic               s1_acc_r;
  logic [LANE_AW-1:0] s1_addr_r;
  logic [HIST_W-1:0]  s1_hist_r;
  logic [SUM_W-1:0]   s1_sum_r;
  logic [CNT_W-1:0]   s1_cnt_r;
  logic               s1_vld_r;
  logic [SUM_W-1:0]   sum_eff;
  logic [CNT_W-1:0]   cnt_eff;

  logic               s2_acc_r;
  logic [LANE_AW-1:0] s2_addr_r;
  logic [SUM_W-1:0]   s2_sum_r;
  logic [CNT_W-1:0]   s2_cnt_r;
  logic signed [2*COMP_W-1:0] px_r, py_r, pz_r;

  logic signed [2*COMP_W+1:0] psum;
  logic signed [SUM_W:0]      tot;
  logic [SUM_W-1:0]           sum_new;
  logic [CNT_W-1:0]           cnt_new;

  always_ff @(posedge clk) begin
    if (ctl.hist_we) hist_mem[ctl.hist_waddr] <= ctl.hist_wdata;
    if (ctl.rd_en) begin
      s1_hist_r <= hist_mem[ctl.hist_raddr];
      s1_sum_r  <= sum_mem[ctl.bank_addr];
      s1_cnt_r  <= cnt_mem[ctl.bank_addr];
      s1_vld_r  <= vld_r[ctl.bank_addr];
      s1_addr_r <= ctl.bank_addr;
    end
  end

  // entries never written read as zero
  assign sum_eff = s1_vld_r ? s1_sum_r : '0;
  assign cnt_eff = s1_vld_r ? s1_cnt_r : '0;

  always_ff @(posedge clk) begin
    px_r      <= $signed(s1_hist_r[COMP_W-1:0])          * $signed(ctl.cur_x);
    py_r      <= $signed(s1_hist_r[2*COMP_W-1:COMP_W])   * $signed(ctl.cur_y);
    pz_r      <= $signed(s1_hist_r[3*COMP_W-1:2*COMP_W]) * $signed(ctl.cur_z);
    s2_sum_r  <= sum_eff;
    s2_cnt_r  <= cnt_eff;
    s2_addr_r <= s1_addr_r;
  end

  always_comb begin
    psum = (2*COMP_W+2)'(px_r) + (2*COMP_W+2)'(py_r) + (2*COMP_W+2)'(pz_r);
    tot  = (SUM_W+1)'($signed(s2_sum_r)) + (SUM_W+1)'(psum);
    if (tot[SUM_W] != tot[SUM_W-1]) begin
      sum_new = tot[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_new = tot[SUM_W-1:0];
    end
    cnt_new = (&s2_cnt_r) ? s2_cnt_r : s2_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (s2_acc_r) begin
      sum_mem[s2_addr_r] <= sum_new;
      cnt_mem[s2_addr_r] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      s1_acc_r <= 1'b0;
      s2_acc_r <= 1'b0;
    end else begin
      s1_acc_r <= ctl.rd_en & ctl.acc_en;
      s2_acc_r <= s1_acc_r;
      if (s2_acc_r) vld_r[s2_addr_r] <= 1'b1;
    end
  end

  assign resp.vld_map = vld_r;
  assign resp.sum     = sum_eff;
  assign resp.cnt     = cnt_eff;

endmodule

### rtl/vacl_div.sv
// ----------------------------------------------------------------------------
// vacl_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vacl_div import vacl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quot,
  output logic [DIVISOR_W-1:0]  rem
);

  localparam int CNT_DW = $clog2(DIVIDEND_W);

  logic                  busy_r, done_r;
  logic [CNT_DW-1:0]     cnt_r;
  logic [DIVIDEND_W-1:0] quot_r;
  logic [DIVISOR_W-1:0]  rem_r, dvs_r;
  logic [DIVISOR_W:0]    trial, diff;
  logic                  ge;

  assign trial = {rem_r, quot_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[DIVIDEND_W-2:0], ge};
      rem_r  <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_DW'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

### rtl/vector_autocorrelation_lags.sv
// ----------------------------------------------------------------------------
// vector_autocorrelation_lags
// Multi-origin autocorrelation of 3-component samples over up to 63 lags.
// ----------------------------------------------------------------------------
// in_if carries beats with cmd: a sample beat (cmd 0) adds its products with
// every earlier origin within max_lag into four lanes, each owning one lag of
// every group of four; a readout beat (cmd 1) lists each lag with pairs on
// out_if, last set on the final beat (one all-zero beat with last when none).
// A sample occupies the block through accept, the lane steps (the lane
// accumulator banks are 16 deep) and a pipeline drain.
// A readout scans past lags without pairs and, for each reported lag,
// waits on the shared 64-step divider that forms the mean.
// Writing origin_spacing re-derives the origin phase on the same divider, so
// the block takes no beat after that write until the division is done.
// Reset clears the index, the lane valid bits and all control state; max_lag
// resets to 64 and origin_spacing to 1.
// Results sit in an output register: a stalled receiver holds the readout
// sequencer, and a new beat is taken as soon as the last result is loaded.
// Registers: max_lag at byte 0, origin_spacing at byte 4, pready always high.
// ----------------------------------------------------------------------------
`include "vector_autocorrelation_lags_defines.svh"

module vector_autocorrelation_lags import vacl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  vacl_in_if.sink     in_if,
  vacl_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SAMP    = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_MOD     = 3'd3;
  localparam logic [2:0] S_RD_SCAN = 3'd4;
  localparam logic [2:0] S_RD_WAIT = 3'd5;
  localparam logic [2:0] S_RD_DIV  = 3'd6;
  localparam logic [2:0] S_RD_EMIT = 3'd7;

  logic [2:0] state_r, state_nxt;

  logic [MAXLAG_W-1:0]  max_lag_r;
  logic [SPACING_W-1:0] sp_r, sp_eff;
  logic                 mod_pend_r;
  logic                 cfg_wr;

  logic [31:0]          n_r, cur_n_r;
  logic [SPACING_W-1:0] phase_r;
  logic [SPACING_W:0]   phase_inc;
  logic [SPACING_W-1:0] r_r [NUM_LANES];
  logic [LANE_AW-1:0]   j_r;
  logic                 drain_r;
  logic [COMP_W-1:0]    cx_r, cy_r, cz_r;
  logic                 exhausted;
  logic [LAGC_W-1:0]    ml_eff;

  logic [TIME_W-1:0]    et_mem [LAGS];
  logic [TIME_W-1:0]    et_q_r, et0_r;

  logic in_acc, samp_go, rdo_go, out_free;

  lane_ctl_t  lane_ctl  [NUM_LANES];
  lane_resp_t lane_resp [NUM_LANES];
  logic [LAGC_W-1:0] lag_k [NUM_LANES];
  logic              en_k  [NUM_LANES];

  logic [LAGS-1:0] pair_map, lag_mask, above_mask;
  logic            any_pairs, more_pairs;
  logic [LAG_W-1:0] rl_r, rl_m1;
  lane_resp_t       sel_resp;

  logic                  div_start, div_busy, div_done;
  logic [DIVIDEND_W-1:0] div_dividend, div_quot, mag;
  logic [DIVISOR_W-1:0]  div_divisor, div_rem, div3;

  logic              neg_r;
  logic [5:0]        res_lag_r;
  logic [TIME_W-1:0] res_elapsed_r;
  logic [31:0]       res_mean_r, res_cnt_r, qc;
  logic              res_last_r;

  logic        out_vld_r;
  logic [5:0]  out_lag_r;
  logic [31:0] out_elapsed_r, out_mean_r, out_cnt_r;
  logic        out_last_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_ORIGIN_SPACING) ? {16'd0, sp_r} : {25'd0, max_lag_r};
  assign sp_eff = (sp_r == '0) ? SPACING_W'(1) : sp_r;
  assign ml_eff = (LAGC_W'(max_lag_r) > LAGC_W'(LAGS)) ? LAGC_W'(LAGS) : LAGC_W'(max_lag_r);

  assign in_acc    = in_if.valid & in_if.ready;
  assign exhausted = &n_r;
  assign samp_go   = in_acc && (in_if.cmd == CMD_SAMPLE) && !exhausted;
  assign rdo_go    = in_acc && (in_if.cmd == CMD_READOUT);
  assign out_free  = !out_vld_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && !mod_pend_r;
  assign phase_inc = {1'b0, phase_r} + 1'b1;

  // lane merge: one bit per lag that has pairs
  assign pair_map[0] = 1'b0;
  for (genvar gi = 1; gi < LAGS; gi++) begin : g_map
    assign pair_map[gi] = lane_resp[(gi-1) % NUM_LANES].vld_map[(gi-1) / NUM_LANES];
  end

  always_comb begin
    for (int i = 0; i < LAGS; i++) begin
      lag_mask[i]   = (i != 0) && (LAGC_W'(i) < ml_eff);
      above_mask[i] = LAG_W'(i) > rl_r;
    end
  end
  assign any_pairs  = |(pair_map & lag_mask);
  assign more_pairs = |(pair_map & lag_mask & above_mask);
  assign rl_m1      = rl_r - 1'b1;
  assign sel_resp   = lane_resp[rl_m1[LANE_IDX_W-1:0]];

  // lane control
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      lag_k[k] = LAGC_W'({j_r, LANE_IDX_W'(k)}) + 1'b1;
      en_k[k]  = (lag_k[k] < ml_eff) && (32'(lag_k[k]) <= cur_n_r) && (r_r[k] == '0);
      lane_ctl[k].rd_en      = (state_r == S_SAMP) || (state_r == S_RD_SCAN);
      lane_ctl[k].acc_en     = (state_r == S_SAMP) && en_k[k];
      lane_ctl[k].bank_addr  = (state_r == S_SAMP) ? j_r : rl_m1[LAG_W-1:LANE_IDX_W];
      lane_ctl[k].hist_raddr = cur_n_r[LAG_W-1:0] - lag_k[k][LAG_W-1:0];
      lane_ctl[k].hist_we    = samp_go;
      lane_ctl[k].hist_waddr = n_r[LAG_W-1:0];
      lane_ctl[k].hist_wdata = {in_if.comp_z, in_if.comp_y, in_if.comp_x};
      lane_ctl[k].cur_x      = cx_r;
      lane_ctl[k].cur_y      = cy_r;
      lane_ctl[k].cur_z      = cz_r;
    end
  end

  for (genvar gl = 0; gl < NUM_LANES; gl++) begin : g_lane
    vacl_lane u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (lane_ctl[gl]),
      .resp (lane_resp[gl])
    );
  end

  // shared divider: origin phase after a spacing write, and the lag means
  assign mag  = sel_resp.sum[SUM_W-1] ? (64'd0 - sel_resp.sum) : sel_resp.sum;
  assign div3 = {2'b00, sel_resp.cnt} + {1'b0, sel_resp.cnt, 1'b0};
  assign div_start    = ((state_r == S_IDLE) && mod_pend_r) || (state_r == S_RD_WAIT);
  assign div_dividend = (state_r == S_IDLE) ? {32'd0, n_r} : mag;
  assign div_divisor  = (state_r == S_IDLE) ? DIVISOR_W'(sp_eff) : div3;

  vacl_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  assign qc = (div_quot > 64'(MEAN_LIMIT)) ? MEAN_LIMIT : div_quot[31:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (mod_pend_r)   state_nxt = S_MOD;
        else if (samp_go) state_nxt = S_SAMP;
        else if (rdo_go)  state_nxt = any_pairs ? S_RD_SCAN : S_RD_EMIT;
      end
      S_SAMP:    if (j_r == LANE_AW'(LANE_DEPTH - 1)) state_nxt = S_DRAIN;
      S_DRAIN:   if (drain_r) state_nxt = S_IDLE;
      S_MOD:     if (div_done) state_nxt = S_IDLE;
      S_RD_SCAN: if (pair_map[rl_r]) state_nxt = S_RD_WAIT;
      S_RD_WAIT: state_nxt = S_RD_DIV;
      S_RD_DIV:  if (div_done) state_nxt = S_RD_EMIT;
      S_RD_EMIT: if (out_free) state_nxt = res_last_r ? S_IDLE : S_RD_SCAN;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // early sample times
  always_ff @(posedge clk) begin
    if (samp_go && (n_r < 32'(LAGS))) et_mem[n_r[LAG_W-1:0]] <= in_if.sample_time;
    et_q_r <= et_mem[rl_r];
    if (samp_go && (n_r == '0)) et0_r <= in_if.sample_time;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (samp_go) begin
      cur_n_r <= n_r;
      cx_r    <= in_if.comp_x;
      cy_r    <= in_if.comp_y;
      cz_r    <= in_if.comp_z;
      for (int k = 0; k < NUM_LANES; k++) begin
        r_r[k] <= mod_sub(phase_r, STEP_W'(k + 1), sp_eff);
      end
    end else if (state_r == S_SAMP) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        r_r[k] <= mod_sub(r_r[k], STEP_W'(NUM_LANES), sp_eff);
      end
    end
    if (state_r == S_RD_WAIT) begin
      neg_r         <= sel_resp.sum[SUM_W-1];
      res_cnt_r     <= sel_resp.cnt;
      res_elapsed_r <= et_q_r - et0_r;
      res_lag_r     <= rl_r;
    end
    if ((state_r == S_RD_DIV) && div_done) begin
      res_mean_r <= neg_r ? (32'd0 - qc) : qc;
      res_last_r <= !more_pairs;
    end
    if ((state_r == S_IDLE) && !mod_pend_r && rdo_go && !any_pairs) begin
      res_lag_r     <= '0;
      res_elapsed_r <= '0;
      res_mean_r    <= '0;
      res_cnt_r     <= '0;
      res_last_r    <= 1'b1;
    end
    if ((state_r == S_RD_EMIT) && out_free) begin
      out_lag_r     <= res_lag_r;
      out_elapsed_r <= res_elapsed_r;
      out_mean_r    <= res_mean_r;
      out_cnt_r     <= res_cnt_r;
      out_last_r    <= res_last_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      max_lag_r  <= MAXLAG_W'(64);
      sp_r       <= SPACING_W'(1);
      mod_pend_r <= 1'b0;
      n_r        <= '0;
      phase_r    <= '0;
      j_r        <= '0;
      drain_r    <= 1'b0;
      rl_r       <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_MAX_LAG) begin
          max_lag_r <= pwdata[MAXLAG_W-1:0];
        end else begin
          sp_r       <= pwdata[SPACING_W-1:0];
          mod_pend_r <= 1'b1;
        end
      end else if ((state_r == S_MOD) && div_done) begin
        mod_pend_r <= 1'b0;
        phase_r    <= div_rem[SPACING_W-1:0];
      end
      if (samp_go && !mod_pend_r) begin
        n_r     <= n_r + 1'b1;
        phase_r <= (phase_inc == {1'b0, sp_eff}) ? '0 : phase_inc[SPACING_W-1:0];
        j_r     <= '0;
      end else if (state_r == S_SAMP) begin
        j_r <= j_r + 1'b1;
      end
      drain_r <= (state_r == S_DRAIN) ? !drain_r : 1'b0;
      if (rdo_go && !mod_pend_r) rl_r <= LAG_W'(1);
      else if ((state_r == S_RD_SCAN) && !pair_map[rl_r]) rl_r <= rl_r + 1'b1;
      else if ((state_r == S_RD_EMIT) && out_free && !res_last_r) rl_r <= rl_r + 1'b1;
      if ((state_r == S_RD_EMIT) && out_free) out_vld_r <= 1'b1;
      else if (out_if.ready) out_vld_r <= 1'b0;
    end
  end

  assign out_if.valid            = out_vld_r;
  assign out_if.lag              = out_lag_r;
  assign out_if.elapsed_time     = out_elapsed_r;
  assign out_if.mean_correlation = out_mean_r;
  assign out_if.pair_count       = out_cnt_r;
  assign out_if.last             = out_last_r;

  `VAL_ASSERT(a_div_free, div_start, !div_busy)
  `VAL_ASSERT_NEXT(a_samp_entry, samp_go, state_r == S_SAMP)
  `VAL_ASSERT_NEXT(a_index_mono, 1'b1, n_r >= $past(n_r))
  `VAL_ASSERT(a_no_beat_busy, state_r != S_IDLE, !in_acc)

endmodule

### verif/vector_autocorrelation_lags_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_autocorrelation_lags_tb
// Drives sample and readout beats through bursts and gaps and stalls the
// result side, predicts every lag result from a local copy of the lag
// accumulators, and checks results in order over several register settings.
// ----------------------------------------------------------------------------
module vector_autocorrelation_lags_tb;
  import vacl_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic        cmd;
    logic [31:0] stamp;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
  } beat_t;

  typedef struct {
    logic [5:0]  lag;
    logic [31:0] elapsed;
    logic [31:0] mean;
    logic [31:0] pairs;
    logic        last;
  } lag_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  vacl_in_if  in_ch();
  vacl_out_if out_ch();

  vector_autocorrelation_lags dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  beat_t       pending_beats[$];
  lag_result_t expected_results[$];
  int          errors = 0;
  int          cycles = 0;
  bit          hold_req = 0;

  // local copy of the correlator state
  logic [6:0]        cur_max_lag = 7'd64;
  logic [15:0]       cur_spacing = 16'd1;
  logic [47:0]       hist_mem[LAGS];
  logic [31:0]       sample_count;
  longint            sum_mem[LAGS];
  logic [31:0]       count_mem[LAGS];
  logic [31:0]       stamp_mem[LAGS];

  function automatic logic [31:0] mean_value(longint s, logic [31:0] c);
    logic [63:0] mag, q, dv;
    dv = 64'd3 * {32'd0, c};
    mag = (s < 0) ? 64'(-s) : 64'(s);
    q = mag / dv;
    if (q > {32'd0, MEAN_LIMIT}) q = {32'd0, MEAN_LIMIT};
    return (s < 0) ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  task automatic correlate(beat_t b);
    int eff, n;
    logic [31:0] o, sp;
    logic [47:0] h;
    longint p, s;
    lag_result_t r;
    eff = (cur_max_lag > 64) ? 64 : int'(cur_max_lag);
    if (b.cmd == CMD_READOUT) begin
      n = 0;
      for (int l = 1; l < eff; l++) begin
        if (count_mem[l] != 0) begin
          r.lag = 6'(l);
          r.elapsed = stamp_mem[l] - stamp_mem[0];
          r.mean = mean_value(sum_mem[l], count_mem[l]);
          r.pairs = count_mem[l];
          r.last = 1'b0;
          expected_results.push_back(r);
          n++;
        end
      end
      if (n == 0) begin
        r = '{6'd0, 32'd0, 32'd0, 32'd0, 1'b1};
        expected_results.push_back(r);
      end else begin
        expected_results[$].last = 1'b1;
      end
    end else begin
      if (sample_count == 32'hFFFF_FFFF) return;
      sp = (cur_spacing == 0) ? 32'd1 : {16'd0, cur_spacing};
      for (int l = 1; l < eff; l++) begin
        if (l > sample_count) break;
        o = sample_count - l;
        if (o % sp != 0) continue;
        h = hist_mem[o % LAGS];
        p = longint'($signed(h[15:0])) * longint'($signed(b.vx))
          + longint'($signed(h[31:16])) * longint'($signed(b.vy))
          + longint'($signed(h[47:32])) * longint'($signed(b.vz));
        s = sum_mem[l] + p;
        if (p > 0 && s < sum_mem[l]) s = 64'h7FFF_FFFF_FFFF_FFFF;
        if (p < 0 && s > sum_mem[l]) s = 64'h8000_0000_0000_0000;
        sum_mem[l] = s;
        if (count_mem[l] != 32'hFFFF_FFFF) count_mem[l]++;
      end
      hist_mem[sample_count % LAGS] = {b.vz, b.vy, b.vx};
      if (sample_count < LAGS) stamp_mem[sample_count] = b.stamp;
      sample_count++;
    end
  endtask

  // sender: bursts of random length separated by random gaps
  beat_t held;
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    logic busy;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= CMD_SAMPLE;
      in_ch.sample_time <= '0;
      in_ch.comp_x <= '0;
      in_ch.comp_y <= '0;
      in_ch.comp_z <= '0;
    end else begin
      busy = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        correlate(held);
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          held = pending_beats.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= held.cmd;
          in_ch.sample_time <= held.stamp;
          in_ch.comp_x <= held.vx;
          in_ch.comp_y <= held.vy;
          in_ch.comp_z <= held.vz;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // receiver: own stall pattern plus one long hold-off
  int hold_left = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    lag_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result beat lag %0d", out_ch.lag);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.lag !== e.lag) report("lag", 32'(out_ch.lag), 32'(e.lag));
          if (out_ch.elapsed_time !== e.elapsed)
            report("elapsed_time", out_ch.elapsed_time, e.elapsed);
          if (out_ch.mean_correlation !== e.mean)
            report("mean_correlation", out_ch.mean_correlation, e.mean);
          if (out_ch.pair_count !== e.pairs)
            report("pair_count", out_ch.pair_count, e.pairs);
          if (out_ch.last !== e.last) report("last", 32'(out_ch.last), 32'(e.last));
        end
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_mode == 0) begin
        out_ch.ready <= 1'b1;
      end else if (stall_mode == 1) begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ch.ready <= ($urandom_range(0, 4) == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("vector_autocorrelation_lags test failed");
      $finish;
    end
  end

  task automatic reg_write(logic regsel, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {regsel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (regsel == REG_MAX_LAG) cur_max_lag = value[6:0];
    else cur_spacing = value[15:0];
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  logic [31:0] stamp_now = 32'd0;
  task automatic push_random(int count, int readout_pct);
    beat_t b;
    for (int i = 0; i < count; i++) begin
      b.cmd = ($urandom_range(0, 99) < readout_pct) ? CMD_READOUT : CMD_SAMPLE;
      if ($urandom_range(0, 15) == 0) stamp_now = $urandom();
      else stamp_now = stamp_now + $urandom_range(1, 5000);
      b.stamp = stamp_now;
      b.vx = rand_comp();
      b.vy = rand_comp();
      b.vz = rand_comp();
      pending_beats.push_back(b);
    end
  endtask

  task automatic run_phase(logic [6:0] ml, logic [15:0] sp, int count, int pct);
    wait_idle();
    // a sample beat can still be in the lanes with nothing expected
    repeat (40) @(posedge clk);
    reg_write(REG_MAX_LAG, {25'd0, ml});
    reg_write(REG_ORIGIN_SPACING, {16'd0, sp});
    push_random(count, pct);
  endtask

  initial begin
    beat_t b;
    sample_count = '0;
    for (int i = 0; i < LAGS; i++) begin
      hist_mem[i] = '0;
      sum_mem[i] = 0;
      count_mem[i] = '0;
      stamp_mem[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty readout, component extremes, time extremes
    b = '{CMD_READOUT, 32'd0, 16'd0, 16'd0, 16'd0};
    pending_beats.push_back(b);
    b = '{CMD_SAMPLE, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h8000};
    pending_beats.push_back(b);
    b = '{CMD_SAMPLE, 32'd0, 16'h8000, 16'h8000, 16'h8000};
    pending_beats.push_back(b);
    b = '{CMD_SAMPLE, 32'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    pending_beats.push_back(b);
    b = '{CMD_SAMPLE, 32'd9, 16'h8000, 16'h7FFF, 16'h0000};
    pending_beats.push_back(b);
    b = '{CMD_SAMPLE, 32'd100, 16'hFFFF, 16'h0001, 16'h8000};
    pending_beats.push_back(b);
    b = '{CMD_SAMPLE, 32'h8000_0000, 16'h0000, 16'h0000, 16'h0000};
    pending_beats.push_back(b);
    b = '{CMD_READOUT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    pending_beats.push_back(b);
    b = '{CMD_READOUT, 32'd0, 16'd0, 16'd0, 16'd0};
    pending_beats.push_back(b);

    run_phase(7'd64, 16'd1, 60, 10);
    hold_req = 1;
    run_phase(7'd2, 16'd3, 25, 15);
    run_phase(7'd0, 16'd0, 15, 25);
    run_phase(7'd1, 16'd65535, 10, 30);
    run_phase(7'd127, 16'd7, 50, 10);
    run_phase(7'd100, 16'd2, 40, 10);
    run_phase(7'd37, 16'd1, 25, 12);

    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("vector_autocorrelation_lags test passed");
    end else begin
      $display("vector_autocorrelation_lags test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/vacl_pkg.sv
rtl/vacl_if.sv
rtl/vacl_lane.sv
rtl/vacl_div.sv
rtl/vector_autocorrelation_lags.sv
verif/vector_autocorrelation_lags_tb.sv
